[rtl/nlr_pkg.sv]
// Shared types and constants for the numeric literal recognizer.
package nlr_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Register indexes
  localparam int unsigned       NUM_REGS      = 6;
  localparam int unsigned       REG_IDX_W     = 3;
  localparam logic [REG_IDX_W-1:0] REG_KIND   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_USE_DL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DL_A   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DL_B   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DL_C   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DL_D   = 3'd5;

  // Depth of the queue between classifier and scanner
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Configuration registers
  typedef struct packed {
    logic       number_kind;
    logic       use_delimiters;
    logic [7:0] delimiter_a;
    logic [7:0] delimiter_b;
    logic [7:0] delimiter_c;
    logic [7:0] delimiter_d;
  } cfg_t;

  // Classified character, one per item
  typedef struct packed {
    logic start;
    logic ws;
    logic dig;
    logic sign;
    logic dot;
    logic expo;
    logic ends;
  } cls_t;

endpackage

[rtl/nlr_classify.sv]
// Front end: turns one character into its class flags.
module nlr_classify import nlr_pkg::*; (
  input  logic [7:0] character,
  input  logic       word_start,
  input  cfg_t       cfg,
  output cls_t       cls
);

  logic dl_hit;

  // A zero delimiter never matches, NUL always ends a word
  always_comb begin
    dl_hit = (cfg.delimiter_a != CH_NUL && character == cfg.delimiter_a) ||
             (cfg.delimiter_b != CH_NUL && character == cfg.delimiter_b) ||
             (cfg.delimiter_c != CH_NUL && character == cfg.delimiter_c) ||
             (cfg.delimiter_d != CH_NUL && character == cfg.delimiter_d);
    cls.start = word_start;
    cls.ws    = (character == CH_SPACE) || (character >= CH_TAB && character <= CH_CR);
    cls.dig   = (character >= CH_ZERO) && (character <= CH_NINE);
    cls.sign  = (character == CH_PLUS) || (character == CH_MINUS);
    cls.dot   = (character == CH_DOT);
    cls.expo  = (character == CH_LOW_E) || (character == CH_UP_E);
    cls.ends  = (character == CH_NUL) || (cfg.use_delimiters && dl_hit);
  end

endmodule

[rtl/nlr_queue.sv]
// Short queue of classified items between front and back.
module nlr_queue import nlr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_data,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cls_t pop_data
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cls_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

[rtl/nlr_scan.sv]
// Back end: scan state machine and registered result.
module nlr_scan import nlr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic number_kind,
  input  logic q_nonempty,
  input  cls_t q_data,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic out_done,
  output logic out_ok
);

  localparam logic [2:0] PH_LEAD    = 3'd0;
  localparam logic [2:0] PH_SIGN    = 3'd1;
  localparam logic [2:0] PH_INT     = 3'd2;
  localparam logic [2:0] PH_FRAC    = 3'd3;
  localparam logic [2:0] PH_EXPWS   = 3'd4;
  localparam logic [2:0] PH_EXPSIGN = 3'd5;
  localparam logic [2:0] PH_EXPDIG  = 3'd6;
  localparam logic [2:0] PH_BAD     = 3'd7;

  logic [2:0] phase, phase_next, ph;
  logic       mseen, mseen_next, ms;
  logic       done, done_next, dn;
  logic       ok, ok_next, okv;

  assign q_pop = q_nonempty && (!out_valid || out_ready);

  // Next scan state for the item at the head of the queue
  always_comb begin
    ph  = q_data.start ? PH_LEAD : phase;
    ms  = q_data.start ? 1'b0 : mseen;
    dn  = q_data.start ? 1'b0 : done;
    okv = q_data.start ? 1'b0 : ok;
    phase_next = ph;
    mseen_next = ms;
    done_next  = dn;
    ok_next    = okv;
    if (!dn) begin
      unique case (ph)
        PH_LEAD, PH_SIGN: begin
          if (ph == PH_LEAD && q_data.ws) begin
            phase_next = PH_LEAD;
          end else if (ph == PH_LEAD && q_data.sign) begin
            phase_next = PH_SIGN;
          end else if (q_data.dig) begin
            mseen_next = 1'b1;
            phase_next = PH_INT;
          end else if (number_kind && q_data.dot) begin
            phase_next = PH_FRAC;
          end else begin
            done_next = 1'b1;
            ok_next   = 1'b0;
          end
        end
        PH_INT: begin
          if (q_data.dig) begin
            mseen_next = 1'b1;
          end else if (number_kind && q_data.dot) begin
            phase_next = PH_FRAC;
          end else if (number_kind && q_data.expo) begin
            phase_next = PH_EXPWS;
          end else begin
            done_next = 1'b1;
            ok_next   = q_data.ends;
          end
        end
        PH_FRAC: begin
          if (q_data.dig) begin
            mseen_next = 1'b1;
          end else if (!ms) begin
            done_next = 1'b1;
            ok_next   = 1'b0;
          end else if (q_data.expo) begin
            phase_next = PH_EXPWS;
          end else begin
            done_next = 1'b1;
            ok_next   = q_data.ends;
          end
        end
        PH_EXPWS: begin
          if (q_data.ws) begin
            phase_next = PH_EXPWS;
          end else if (q_data.sign) begin
            phase_next = PH_EXPSIGN;
          end else if (q_data.dig) begin
            phase_next = PH_EXPDIG;
          end else begin
            done_next = 1'b1;
            ok_next   = 1'b0;
          end
        end
        PH_EXPSIGN: begin
          if (q_data.dig) begin
            phase_next = PH_EXPDIG;
          end else begin
            done_next = 1'b1;
            ok_next   = 1'b0;
          end
        end
        PH_EXPDIG: begin
          if (!q_data.dig) begin
            done_next = 1'b1;
            ok_next   = q_data.ends;
          end
        end
        default: begin
          done_next = 1'b1;
          ok_next   = 1'b0;
        end
      endcase
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      mseen <= 1'b0;
      done  <= 1'b0;
      ok    <= 1'b0;
    end else if (q_pop) begin
      phase <= phase_next;
      mseen <= mseen_next;
      done  <= done_next;
      ok    <= ok_next;
    end
  end

  // Output register; is_number reads zero until decided
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_done <= done_next;
      out_ok   <= done_next && ok_next;
    end
  end

`ifndef ASSERT_OFF
  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_ok || out_done))
    else $error("verdict shown before it is settled");
  a_verdict_held: assert property (@(posedge clk) disable iff (rst)
    (q_pop && done && !q_data.start) |=> (out_done && out_ok == $past(ok)))
    else $error("settled verdict changed within a word");
  a_int_has_digit: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_INT) |-> mseen)
    else $error("integer phase without a mantissa digit");
  a_no_bad_phase: assert property (@(posedge clk) disable iff (rst)
    phase != PH_BAD)
    else $error("scan phase took the unused code");
`endif

endmodule

[rtl/numeric_literal_recognizer.sv]
// Top level: configuration registers, classifier, queue and scanner.
//
// Checks, character by character, whether each word is a numeric literal.
// Input stream: s_tdata carries one character, s_tuser flags the first
// character of a word. Output stream: one result per character, m_tdata
// bit 0 = decided, bit 1 = is_number (zero until decided).
// The APB port holds number_kind, use_delimiters and four delimiters at
// byte addresses 0, 4, ..., 20; write them only while the stream is idle.
// A character is classified into the queue when it is taken, and the scan
// step then loads its result from the queue into the output register; a low
// m_tready can stall it in the queue between the two. Throughput: one character
// per cycle while m_tready is high, set by the single scan step per cycle.
// When m_tready is low the result holds in the output register and the
// queue absorbs up to QUEUE_DEPTH further characters before s_tready drops.
// Reset (rst, synchronous) empties the queue, drops m_tvalid, restores the
// register defaults (floating-point format, no delimiters) and starts the
// scan as if a word began.
module numeric_literal_recognizer import nlr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] character
  input  logic        s_tuser,   // [0] word_start
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] decided, [1] is_number, [7:2] zero
);

  cfg_t                 cfg;
  cls_t                 cls;
  cls_t                 q_data;
  logic                 q_full;
  logic                 q_nonempty;
  logic                 q_pop;
  logic                 push;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 out_done;
  logic                 out_ok;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; unlisted indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_kind    <= 1'b1;
      cfg.use_delimiters <= 1'b0;
      cfg.delimiter_a    <= '0;
      cfg.delimiter_b    <= '0;
      cfg.delimiter_c    <= '0;
      cfg.delimiter_d    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KIND:   cfg.number_kind    <= pwdata[0];
        REG_USE_DL: cfg.use_delimiters <= pwdata[0];
        REG_DL_A:   cfg.delimiter_a    <= pwdata[7:0];
        REG_DL_B:   cfg.delimiter_b    <= pwdata[7:0];
        REG_DL_C:   cfg.delimiter_c    <= pwdata[7:0];
        REG_DL_D:   cfg.delimiter_d    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_KIND:   prdata = {31'b0, cfg.number_kind};
      REG_USE_DL: prdata = {31'b0, cfg.use_delimiters};
      REG_DL_A:   prdata = {24'b0, cfg.delimiter_a};
      REG_DL_B:   prdata = {24'b0, cfg.delimiter_b};
      REG_DL_C:   prdata = {24'b0, cfg.delimiter_c};
      REG_DL_D:   prdata = {24'b0, cfg.delimiter_d};
      default:    prdata = '0;
    endcase
  end

  // Front end
  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  nlr_classify u_classify (
    .character  (s_tdata),
    .word_start (s_tuser),
    .cfg        (cfg),
    .cls        (cls)
  );

  nlr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_data)
  );

  // Back end
  nlr_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .number_kind (cfg.number_kind),
    .q_nonempty  (q_nonempty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_done    (out_done),
    .out_ok      (out_ok)
  );

  assign m_tdata = {6'b0, out_ok, out_done};

endmodule
